[rtl/credential_record_table_assert.svh]
// Assertion macros for the credential record table.
`ifndef CREDENTIAL_RECORD_TABLE_ASSERT_SVH
`define CREDENTIAL_RECORD_TABLE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every clock edge outside reset.
`define CRT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("credential record table assertion failed");

// Condition must never be true outside reset.
`define CRT_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("credential record table forbidden condition seen");

`else

`define CRT_ASSERT(lbl, prop)
`define CRT_ASSERT_NEVER(lbl, cond)

`endif

`endif

[rtl/crt_pkg.sv]
// Types and constants shared by the credential record table modules.
package crt_pkg;

  localparam int unsigned STORE_DEPTH = 64;
  localparam int unsigned IDX_W       = $clog2(STORE_DEPTH);
  localparam int unsigned HASH_W      = 64;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [2:0] CMD_READ      = 3'd0;
  localparam logic [2:0] CMD_DELETE    = 3'd1;
  localparam logic [2:0] CMD_SET       = 3'd2;
  localparam logic [2:0] CMD_FIND_ID   = 3'd3;
  localparam logic [2:0] CMD_FIND_HASH = 3'd4;
  localparam logic [2:0] CMD_FIND_FREE = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_MISS  = 2'd2;

  typedef struct packed {
    logic [2:0]        command;
    logic [15:0]       slot;
    logic [15:0]       record_id;
    logic [HASH_W-1:0] hash_in;
  } crt_req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [7:0]        slot_out;
    logic [7:0]        id_out;
    logic [HASH_W-1:0] hash_out;
  } crt_rsp_t;

  typedef enum logic [2:0] {
    OP_READ,
    OP_DELETE,
    OP_SET,
    OP_FIND_ID,
    OP_FIND_HASH,
    OP_FIND_FREE,
    OP_REJECT
  } crt_op_e;

  // Decoded operation handed from the front end to the execution back end.
  typedef struct packed {
    crt_op_e           kind;
    logic [IDX_W-1:0]  idx;
    logic [7:0]        id;
    logic [HASH_W-1:0] hash;
  } crt_op_t;

  typedef struct packed {
    logic [7:0]        id;
    logic [HASH_W-1:0] hash;
  } crt_entry_t;

endpackage

[rtl/crt_front.sv]
// Front end: command decode, range checks and hash masking.
module crt_front import crt_pkg::*; #(
  parameter int unsigned MIN_SLOT   = 1,
  parameter int unsigned MAX_SLOT   = 63,
  parameter int unsigned HASH_BYTES = 8
) (
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  crt_req_t in_req_i,
  output logic     op_valid_o,
  input  logic     op_ready_i,
  output crt_op_t  op_o
);

  localparam logic [15:0] MinSlot16 = 16'(MIN_SLOT);
  localparam logic [15:0] MaxSlot16 = 16'(MAX_SLOT);
  localparam logic [HASH_W-1:0] HashMask = (HASH_BYTES >= 8) ? '1 :
      ((HASH_W'(1) << (8 * HASH_BYTES)) - HASH_W'(1));

  logic slot_ok;
  logic rid_ok;

  assign slot_ok = (in_req_i.slot >= MinSlot16) && (in_req_i.slot <= MaxSlot16);
  assign rid_ok  = (in_req_i.record_id >= MinSlot16) && (in_req_i.record_id <= MaxSlot16);

  always_comb begin
    op_o.idx  = in_req_i.slot[IDX_W-1:0];
    op_o.id   = in_req_i.slot[7:0];
    op_o.hash = in_req_i.hash_in & HashMask;
    unique case (in_req_i.command)
      CMD_READ:      op_o.kind = slot_ok ? OP_READ : OP_REJECT;
      CMD_DELETE:    op_o.kind = slot_ok ? OP_DELETE : OP_REJECT;
      CMD_SET:       op_o.kind = slot_ok ? OP_SET : OP_REJECT;
      CMD_FIND_ID: begin
        op_o.kind = rid_ok ? OP_FIND_ID : OP_REJECT;
        op_o.idx  = in_req_i.record_id[IDX_W-1:0];
        op_o.id   = in_req_i.record_id[7:0];
      end
      CMD_FIND_HASH: op_o.kind = OP_FIND_HASH;
      CMD_FIND_FREE: op_o.kind = OP_FIND_FREE;
      default:       op_o.kind = OP_REJECT;
    endcase
  end

  assign op_valid_o = in_valid_i;
  assign in_ready_o = op_ready_i;

endmodule

[rtl/crt_fifo.sv]
// Two-entry queue of decoded operations between front and back end.
module crt_fifo import crt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_valid_i,
  output logic    push_ready_o,
  input  crt_op_t push_op_i,
  output logic    pop_valid_o,
  input  logic    pop_ready_i,
  output crt_op_t pop_op_o
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  crt_op_t           buf_q [QUEUE_DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              push;
  logic              pop;

  assign push_ready_o = (count_q != CntW'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_op_o     = buf_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= push_op_i;
    end
  end

endmodule

[rtl/crt_back.sv]
// Back end: record memory, slot scan sequencer and result register.
`include "credential_record_table_assert.svh"

module crt_back import crt_pkg::*; #(
  parameter int unsigned MIN_SLOT = 1,
  parameter int unsigned MAX_SLOT = 63
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     op_valid_i,
  output logic     op_ready_o,
  input  crt_op_t  op_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output crt_rsp_t out_rsp_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_LOOK = 3'b010,
    S_SCAN = 3'b100
  } crt_state_e;

  localparam logic [7:0] MinSlot8  = 8'(MIN_SLOT);
  localparam logic [7:0] MaxSlot8  = 8'(MAX_SLOT);
  localparam logic       ScanEmpty = (MIN_SLOT > MAX_SLOT);

  crt_state_e        state_q, state_d;
  crt_op_t           op_q, op_d;
  logic [7:0]        scan_q, scan_d;
  crt_rsp_t          out_q, out_d;
  logic              out_valid_q, out_valid_d;

  crt_entry_t        mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] vld_q;
  crt_entry_t        rd_data_q;
  logic              rd_vld_q;
  logic [IDX_W-1:0]  rd_addr;
  logic              mem_we;
  logic              vld_set;
  logic              vld_clr;

  logic [7:0]        entry_id;
  logic [HASH_W-1:0] entry_hash;
  logic              hit;

  assign entry_id   = rd_vld_q ? rd_data_q.id : '0;
  assign entry_hash = rd_vld_q ? rd_data_q.hash : '0;
  assign hit = (op_q.kind == OP_FIND_HASH) ? (entry_hash == op_q.hash) : (entry_id == '0);

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    scan_d      = scan_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    op_ready_o  = 1'b0;
    rd_addr     = op_i.idx;
    mem_we      = 1'b0;
    vld_set     = 1'b0;
    vld_clr     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (!out_valid_q) begin
          op_ready_o = 1'b1;
          if (op_valid_i) begin
            op_d  = op_i;
            out_d = '{status: ST_OK, slot_out: '0, id_out: '0, hash_out: '0};
            unique case (op_i.kind)
              OP_READ, OP_FIND_ID: state_d = S_LOOK;
              OP_DELETE: begin
                vld_clr     = 1'b1;
                out_valid_d = 1'b1;
              end
              OP_SET: begin
                mem_we      = 1'b1;
                vld_set     = 1'b1;
                out_valid_d = 1'b1;
              end
              OP_FIND_HASH, OP_FIND_FREE: begin
                if (ScanEmpty) begin
                  out_d.status = ST_MISS;
                  out_valid_d  = 1'b1;
                end else begin
                  scan_d  = MinSlot8;
                  rd_addr = MinSlot8[IDX_W-1:0];
                  state_d = S_SCAN;
                end
              end
              OP_REJECT: begin
                out_d.status = ST_RANGE;
                out_valid_d  = 1'b1;
              end
              default: begin
                out_d.status = ST_RANGE;
                out_valid_d  = 1'b1;
              end
            endcase
          end
        end
      end
      S_LOOK: begin
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
        if (op_q.kind == OP_READ) begin
          out_d.id_out   = entry_id;
          out_d.hash_out = entry_hash;
        end else if (entry_id == op_q.id) begin
          out_d.slot_out = op_q.id;
        end else begin
          out_d.status = ST_MISS;
        end
      end
      S_SCAN: begin
        if (hit) begin
          out_d.slot_out = scan_q;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end else if (scan_q == MaxSlot8) begin
          out_d.status = ST_MISS;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end else begin
          scan_d  = scan_q + 8'd1;
          rd_addr = scan_d[IDX_W-1:0];
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      vld_q       <= '0;
      rd_vld_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      rd_vld_q    <= vld_q[rd_addr];
      if (vld_set) begin
        vld_q[op_i.idx] <= 1'b1;
      end else if (vld_clr) begin
        vld_q[op_i.idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    scan_q <= scan_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[op_i.idx] <= '{id: op_i.id, hash: op_i.hash};
    end
    rd_data_q <= mem[rd_addr];
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  `CRT_ASSERT(a_scan_in_bounds, (state_q == S_SCAN) |-> (scan_q >= MinSlot8 && scan_q <= MaxSlot8))
  `CRT_ASSERT(a_busy_no_result, (state_q != S_IDLE) |-> !out_valid_q)
  `CRT_ASSERT(a_take_when_free, (op_valid_i && op_ready_o) |=> (state_q != S_IDLE) || out_valid_q)
  `CRT_ASSERT_NEVER(a_status_code, out_valid_q && out_q.status != ST_OK && out_q.status != ST_RANGE && out_q.status != ST_MISS)

endmodule

[rtl/credential_record_table.sv]
// Credential record table: 64-slot id/hash store with lookup and scan commands.
//
// One command per transfer, one result per command. Commands are decoded and range checked on
// entry and wait in a two-entry queue, so the input side keeps taking up to two commands while
// the record store is busy or a result waits; the back end starts the next command only after
// the previous result has been transferred. From the input transfer to the output, delete, set
// and rejected commands pass through the queue and the result register; read and find by id
// add one registered read of the record memory; find by hash and find free walk the slots from
// MIN_SLOT to MAX_SLOT through the single memory read port, one slot per cycle, and stop at the
// first hit. The store reads as all free and zero after reset through per-slot valid bits; no
// clearing pass is needed.
module credential_record_table import crt_pkg::*; #(
  parameter int unsigned MIN_SLOT   = 1,
  parameter int unsigned MAX_SLOT   = 63,
  parameter int unsigned HASH_BYTES = 8
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  crt_req_t in_req_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output crt_rsp_t out_rsp_o
);

  logic    fe_valid;
  logic    fe_ready;
  crt_op_t fe_op;
  logic    be_valid;
  logic    be_ready;
  crt_op_t be_op;

  crt_front #(
    .MIN_SLOT  (MIN_SLOT),
    .MAX_SLOT  (MAX_SLOT),
    .HASH_BYTES(HASH_BYTES)
  ) u_front (
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_req_i  (in_req_i),
    .op_valid_o(fe_valid),
    .op_ready_i(fe_ready),
    .op_o      (fe_op)
  );

  crt_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(fe_valid),
    .push_ready_o(fe_ready),
    .push_op_i   (fe_op),
    .pop_valid_o (be_valid),
    .pop_ready_i (be_ready),
    .pop_op_o    (be_op)
  );

  crt_back #(
    .MIN_SLOT(MIN_SLOT),
    .MAX_SLOT(MAX_SLOT)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (be_valid),
    .op_ready_o (be_ready),
    .op_i       (be_op),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the credential record table: directed rows, then random commands.
module tb;
  import crt_pkg::*;

  localparam int unsigned TB_MIN_SLOT   = 1;
  localparam int unsigned TB_MAX_SLOT   = 63;
  localparam int unsigned TB_HASH_BYTES = 8;
  localparam logic [HASH_W-1:0] HASH_KEEP =
      (TB_HASH_BYTES >= 8) ? '1 : ((64'd1 << (8 * TB_HASH_BYTES)) - 64'd1);

  localparam logic [2:0] CMD_BAD_LO = 3'd6;
  localparam logic [2:0] CMD_BAD_HI = 3'd7;

  localparam int RANDOM_PER_PHASE = 230;
  localparam int HOLD_CYCLES      = 500;
  localparam int WATCHDOG_LIMIT   = 4000;
  localparam int DRAIN_CYCLES     = 100;

  typedef struct {
    crt_req_t req;
    bit       fixed;
    crt_rsp_t rsp;
  } dir_row_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  crt_req_t in_req = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  crt_rsp_t out_rsp;

  // typed expectation traveling with the request, tb side only
  bit       in_fixed = 1'b0;
  crt_rsp_t in_fixed_rsp = '0;

  logic [7:0]        id_tab   [STORE_DEPTH];
  logic [HASH_W-1:0] hash_tab [STORE_DEPTH];
  crt_rsp_t          expected_q [$];
  dir_row_t          dir_rows [$];

  int mismatches      = 0;
  int quiet_cycles    = 0;
  int sender_idle_pct = 0;
  int stall_pct       = 0;
  bit hold_req        = 1'b0;

  credential_record_table #(
    .MIN_SLOT  (TB_MIN_SLOT),
    .MAX_SLOT  (TB_MAX_SLOT),
    .HASH_BYTES(TB_HASH_BYTES)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_rsp_o  (out_rsp)
  );

  always #6 clk_i = ~clk_i;

  task automatic note_mismatch(input string field, input logic [63:0] got,
                               input logic [63:0] want);
    $display("MISMATCH %s: got %h expected %h", field, got, want);
    mismatches++;
  endtask

  function automatic bit slot_valid(logic [15:0] v);
    return (v >= TB_MIN_SLOT) && (v <= TB_MAX_SLOT);
  endfunction

  // Applies one command to the shadow store and returns its result.
  function automatic crt_rsp_t table_apply(crt_req_t r);
    crt_rsp_t          res;
    logic [HASH_W-1:0] key;
    logic [IDX_W-1:0]  idx;
    bit                hit;
    res        = '0;
    res.status = ST_RANGE;
    key        = r.hash_in & HASH_KEEP;
    idx        = r.slot[IDX_W-1:0];
    hit        = 1'b0;
    case (r.command)
      CMD_READ: if (slot_valid(r.slot)) begin
        res.status   = ST_OK;
        res.id_out   = id_tab[idx];
        res.hash_out = hash_tab[idx] & HASH_KEEP;
      end
      CMD_DELETE: if (slot_valid(r.slot)) begin
        res.status    = ST_OK;
        id_tab[idx]   = '0;
        hash_tab[idx] = '0;
      end
      CMD_SET: if (slot_valid(r.slot)) begin
        res.status    = ST_OK;
        id_tab[idx]   = r.slot[7:0];
        hash_tab[idx] = key;
      end
      CMD_FIND_ID: if (slot_valid(r.record_id)) begin
        if ({8'd0, id_tab[r.record_id[IDX_W-1:0]]} == r.record_id) begin
          res.status   = ST_OK;
          res.slot_out = r.record_id[7:0];
        end else begin
          res.status = ST_MISS;
        end
      end
      CMD_FIND_HASH: begin
        res.status = ST_MISS;
        for (int s = TB_MIN_SLOT; s <= TB_MAX_SLOT; s++) begin
          if (!hit && ((hash_tab[s[IDX_W-1:0]] & HASH_KEEP) == key)) begin
            hit          = 1'b1;
            res.status   = ST_OK;
            res.slot_out = s[7:0];
          end
        end
      end
      CMD_FIND_FREE: begin
        res.status = ST_MISS;
        for (int s = TB_MIN_SLOT; s <= TB_MAX_SLOT; s++) begin
          if (!hit && (id_tab[s[IDX_W-1:0]] == 8'd0)) begin
            hit          = 1'b1;
            res.status   = ST_OK;
            res.slot_out = s[7:0];
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic logic [15:0] pick_slot();
    int p;
    p = $urandom_range(99);
    if (p < 85) return 16'($urandom_range(TB_MAX_SLOT, TB_MIN_SLOT));
    else if (p < 88) return 16'd0;
    else if (p < 94) return 16'($urandom_range(255, 64));
    else return 16'($urandom);
  endfunction

  function automatic logic [HASH_W-1:0] pick_hash(logic [2:0] cmd);
    int p;
    int thr;
    int j;
    p   = $urandom_range(99);
    thr = (cmd == CMD_FIND_HASH) ? 50 : 15;
    j   = $urandom_range(TB_MAX_SLOT, TB_MIN_SLOT);
    if (p < thr) return hash_tab[j[IDX_W-1:0]];
    else if (p < thr + 8) return '0;
    else if (p < thr + 11) return '1;
    else return {$urandom, $urandom};
  endfunction

  function automatic crt_req_t rand_req();
    crt_req_t r;
    int       p;
    p = $urandom_range(99);
    if (p < 18) r.command = CMD_READ;
    else if (p < 26) r.command = CMD_DELETE;
    else if (p < 46) r.command = CMD_SET;
    else if (p < 60) r.command = CMD_FIND_ID;
    else if (p < 76) r.command = CMD_FIND_HASH;
    else if (p < 92) r.command = CMD_FIND_FREE;
    else if (p < 96) r.command = CMD_BAD_LO;
    else r.command = CMD_BAD_HI;
    r.slot      = pick_slot();
    r.record_id = pick_slot();
    r.hash_in   = pick_hash(r.command);
    return r;
  endfunction

  function automatic dir_row_t mk_row(logic [2:0] cmd, logic [15:0] slot, logic [15:0] rid,
                                      logic [HASH_W-1:0] hash, bit fixed, logic [1:0] st,
                                      logic [7:0] slot_o, logic [7:0] id_o,
                                      logic [HASH_W-1:0] hash_o);
    dir_row_t row;
    row.req.command   = cmd;
    row.req.slot      = slot;
    row.req.record_id = rid;
    row.req.hash_in   = hash;
    row.fixed         = fixed;
    row.rsp.status    = st;
    row.rsp.slot_out  = slot_o;
    row.rsp.id_out    = id_o;
    row.rsp.hash_out  = hash_o;
    return row;
  endfunction

  task automatic send_req(input crt_req_t r, input bit fixed, input crt_rsp_t rsp);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid     <= 1'b1;
    in_req       <= r;
    in_fixed     <= fixed;
    in_fixed_rsp <= rsp;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : monitor
    crt_rsp_t want;
    if (rst_ni) begin
      if (in_valid && in_ready) begin
        want = table_apply(in_req);
        if (in_fixed) want = in_fixed_rsp;
        expected_q.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          note_mismatch("unexpected transfer", out_rsp.hash_out, '0);
        end else begin
          want = expected_q.pop_front();
          if (out_rsp.status !== want.status)
            note_mismatch("status", out_rsp.status, want.status);
          if (out_rsp.slot_out !== want.slot_out)
            note_mismatch("slot_out", out_rsp.slot_out, want.slot_out);
          if (out_rsp.id_out !== want.id_out)
            note_mismatch("id_out", out_rsp.id_out, want.id_out);
          if (out_rsp.hash_out !== want.hash_out)
            note_mismatch("hash_out", out_rsp.hash_out, want.hash_out);
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Output side: random stalls, plus one long hold-off on request.
  initial begin : receiver
    int hold_cnt;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready <= 1'b0;
        for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) @(posedge clk_i);
        hold_req = 1'b0;
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin : stimulus
    crt_rsp_t none;
    crt_req_t fill;
    none = '0;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      id_tab[i]   = '0;
      hash_tab[i] = '0;
    end

    dir_rows.push_back(mk_row(CMD_READ, 16'd1, 16'($urandom), {$urandom, $urandom},
                              1, ST_OK, 8'd0, 8'd0, '0));
    dir_rows.push_back(mk_row(CMD_FIND_FREE, 16'($urandom), 16'($urandom), {$urandom, $urandom},
                              1, ST_OK, 8'd1, 8'd0, '0));
    // freed slots hold an all-zero hash
    dir_rows.push_back(mk_row(CMD_FIND_HASH, 16'($urandom), 16'($urandom), '0,
                              1, ST_OK, 8'd1, 8'd0, '0));
    dir_rows.push_back(mk_row(CMD_FIND_ID, 16'($urandom), 16'd1, '1,
                              1, ST_MISS, 8'd0, 8'd0, '0));
    dir_rows.push_back(mk_row(CMD_READ, 16'd0, 16'd5, '1, 1, ST_RANGE, 8'd0, 8'd0, '0));
    dir_rows.push_back(mk_row(CMD_READ, 16'd64, 16'd5, '1, 1, ST_RANGE, 8'd0, 8'd0, '0));
    dir_rows.push_back(mk_row(CMD_READ, 16'hffff, 16'd5, '1, 1, ST_RANGE, 8'd0, 8'd0, '0));
    dir_rows.push_back(mk_row(CMD_DELETE, 16'd0, 16'd1, '0, 1, ST_RANGE, 8'd0, 8'd0, '0));
    dir_rows.push_back(mk_row(CMD_SET, 16'h8000, 16'd1, '1, 1, ST_RANGE, 8'd0, 8'd0, '0));
    dir_rows.push_back(mk_row(CMD_FIND_ID, 16'd1, 16'd0, '0, 1, ST_RANGE, 8'd0, 8'd0, '0));
    dir_rows.push_back(mk_row(CMD_FIND_ID, 16'd1, 16'd64, '0, 1, ST_RANGE, 8'd0, 8'd0, '0));
    dir_rows.push_back(mk_row(CMD_FIND_ID, 16'd1, 16'hffff, '0, 1, ST_RANGE, 8'd0, 8'd0, '0));
    dir_rows.push_back(mk_row(CMD_SET, 16'd1, 16'hffff, '1, 1, ST_OK, 8'd0, 8'd0, '0));
    dir_rows.push_back(mk_row(CMD_READ, 16'd1, 16'd0, '0, 1, ST_OK, 8'd0, 8'd1, '1));
    dir_rows.push_back(mk_row(CMD_SET, 16'd63, 16'd0, 64'h0123_4567_89ab_cdef,
                              1, ST_OK, 8'd0, 8'd0, '0));
    dir_rows.push_back(mk_row(CMD_READ, 16'd63, 16'($urandom), '0, 0, ST_OK, 8'd0, 8'd0, '0));
    dir_rows.push_back(mk_row(CMD_FIND_HASH, 16'd0, 16'd0, '1, 0, ST_OK, 8'd0, 8'd0, '0));
    dir_rows.push_back(mk_row(CMD_FIND_ID, 16'd0, 16'd63, '0, 0, ST_OK, 8'd0, 8'd0, '0));
    dir_rows.push_back(mk_row(CMD_FIND_FREE, 16'd0, 16'd0, '0, 0, ST_OK, 8'd0, 8'd0, '0));
    dir_rows.push_back(mk_row(CMD_DELETE, 16'd1, 16'd0, '1, 1, ST_OK, 8'd0, 8'd0, '0));
    dir_rows.push_back(mk_row(CMD_FIND_HASH, 16'd0, 16'd0, '0, 0, ST_OK, 8'd0, 8'd0, '0));
    dir_rows.push_back(mk_row(CMD_FIND_HASH, 16'd0, 16'd0, 64'h5555_aaaa_5555_aaaa,
                              0, ST_OK, 8'd0, 8'd0, '0));
    dir_rows.push_back(mk_row(CMD_BAD_LO, 16'd1, 16'd1, {$urandom, $urandom},
                              1, ST_RANGE, 8'd0, 8'd0, '0));
    dir_rows.push_back(mk_row(CMD_BAD_HI, 16'($urandom), 16'($urandom), {$urandom, $urandom},
                              1, ST_RANGE, 8'd0, 8'd0, '0));
    dir_rows.push_back(mk_row(CMD_READ, 16'd1, 16'd0, '0, 0, ST_OK, 8'd0, 8'd0, '0));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].fixed, dir_rows[i].rsp);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  stall_pct = 0;  end
        1: begin sender_idle_pct = 64; stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  stall_pct = 64; end
        default: begin sender_idle_pct = 33; stall_pct = 33; end
      endcase
      // fill every slot so searches for free space can miss
      for (int s = TB_MIN_SLOT; s <= TB_MAX_SLOT; s++) begin
        fill.command   = CMD_SET;
        fill.slot      = 16'(s);
        fill.record_id = 16'($urandom);
        fill.hash_in   = pick_hash(CMD_SET);
        send_req(fill, 1'b0, none);
      end
      fill.command = CMD_FIND_FREE;
      send_req(fill, 1'b0, none);
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (phase == 0 && n == 100) hold_req = 1'b1;
        send_req(rand_req(), 1'b0, none);
      end
    end
    in_valid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
